// ===== hw/rtl/tape_machine_execute_core_top_defines.svh =====
// Assertion macros shared by the tape machine execute core RTL.
// Included by the top level, which carries the concurrent checks; needs no other file.
`ifndef TAPE_MACHINE_EXECUTE_CORE_TOP_DEFINES_SVH
`define TAPE_MACHINE_EXECUTE_CORE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TMEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TMEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tmec_pkg.sv =====
// Package of the tape machine execute core: sizes, opcode and status codes,
// and the tape address helper. Depends on nothing.
`default_nettype none

package tmec_pkg;

    // Tape size; the address arithmetic assumes a power of two.
    localparam int TAPE_CELLS = 32768;
    localparam int TAPE_AW    = $clog2(TAPE_CELLS);
    // Program store depth; the counter holds one more bit to reach the length.
    localparam int CODE_DEPTH = 4096;
    localparam int PC_W       = $clog2(CODE_DEPTH) + 1;
    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 16;
    localparam int MODE_W     = 3;

    typedef logic [PC_W-1:0]            t_pc;
    typedef logic [TAPE_AW-1:0]         t_addr;
    typedef logic [BYTE_W-1:0]          t_byte;
    typedef logic signed [OFFSET_W-1:0] t_offset;

    typedef enum logic [MODE_W-1:0] {
        OP_INVALID = 3'd0,
        OP_ADD     = 3'd1,
        OP_JFWD    = 3'd2,
        OP_JBWD    = 3'd3,
        OP_ZERO    = 3'd4,
        OP_PUT     = 3'd5,
        OP_GET     = 3'd6
    } t_opcode;

    typedef enum logic [1:0] {
        ST_EXECUTED = 2'd0,
        ST_FINISHED = 2'd1,
        ST_HALTED   = 2'd2
    } t_status;

    // Pointer plus signed offset, wrapping around the tape in both directions.
    function automatic t_addr wrap_addr(input t_addr base, input t_offset offset);
        t_addr off_ext;
        off_ext = t_addr'(offset);
        return t_addr'(base + off_ext);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tmec_channels.sv =====
// Valid/ready channel interfaces of the tape machine execute core.
// Depends on tmec_pkg for the payload types.
`default_nettype none

// Instruction channel: one decoded instruction and one input byte per transaction.
interface tmec_instr_if;
    import tmec_pkg::*;

    logic    valid;
    logic    ready;
    logic [MODE_W-1:0] mode;
    t_offset ptr_offset;
    t_byte   add_value;
    t_pc     jump_target;
    t_byte   in_byte;

    modport source (
        output valid, mode, ptr_offset, add_value, jump_target, in_byte,
        input  ready
    );
    modport sink (
        input  valid, mode, ptr_offset, add_value, jump_target, in_byte,
        output ready
    );
endinterface

// Result channel: next counter, optional output byte and status per transaction.
interface tmec_result_if;
    import tmec_pkg::*;

    logic       valid;
    logic       ready;
    t_pc        next_pc;
    logic       out_valid;
    t_byte      out_byte;
    logic [1:0] status;

    modport source (
        output valid, next_pc, out_valid, out_byte, status,
        input  ready
    );
    modport sink (
        input  valid, next_pc, out_valid, out_byte, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/tape_machine_execute_core_top.sv =====
// Top level of the tape machine execute core: tape memory, pointer, counter.
// Depends on tmec_pkg, the channel interfaces and the assertion macro header.
//
//  Channel    Direction  Handshake      Transaction
//  i_instr    in         valid/ready    decoded instruction and input byte
//  o_result   out        valid/ready    next_pc, out_valid, out_byte, status
//  i_cfg_*    in         write enable   program_length
//
// One instruction is accepted per cycle while the result side takes results and no clearing
// pass runs; the tape is read at the accepting edge into the execute stage, and the result
// is executed from there into the output register, which offers it on o_result.
// The tape read port and the read-modify-write of one cell per cycle set this rate;
// a write to the cell read by the next instruction is forwarded.
// After reset a clearing pass zeroes all TAPE_CELLS (32768) tape cells, one cell per cycle;
// no instruction is accepted then, configuration writes are.
// A stalled result holds the execute stage, which in turn holds the input.
`default_nettype none
`include "tape_machine_execute_core_top_defines.svh"

module tape_machine_execute_core_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire tmec_pkg::t_pc        i_cfg_data,
    tmec_instr_if.sink                i_instr,
    tmec_result_if.source             o_result
);
    import tmec_pkg::*;

    // Tape memory and its registered read data.
    t_byte r_tape [TAPE_CELLS];
    t_byte r_mem_q;

    // Control state.
    logic  r_clr_busy;
    t_addr r_clr_addr;
    t_pc   r_len;
    t_pc   r_pc;
    t_addr r_ptr;
    logic  r_e_valid;
    logic  r_o_valid;

    // Execute stage payload.
    logic [MODE_W-1:0] r_e_mode;
    t_addr r_e_addr;
    t_byte r_e_add;
    t_pc   r_e_target;
    t_byte r_e_in;
    logic  r_e_fwd;
    t_byte r_e_fwd_data;

    // Output register payload.
    t_pc     r_o_next_pc;
    logic    r_o_out_valid;
    t_byte   r_o_out_byte;
    t_status r_o_status;

    // Next values and execute stage logic.
    t_pc     n_pc;
    t_addr   n_ptr;
    logic    out_free;
    logic    e_commit;
    logic    in_ready;
    logic    in_accept;
    logic    e_exec;
    t_byte   e_cell;
    logic    e_wr_en;
    t_byte   e_wr_data;
    logic    e_out_valid;
    t_byte   e_out_byte;
    t_status e_status;
    t_addr   ptr_eff;
    t_addr   in_addr;
    logic    fwd_hit;
    logic    mem_we;
    t_addr   mem_waddr;
    t_byte   mem_wdata;
    logic    e_straight;

    // Handshake: the execute stage moves on whenever the output register frees up.
    assign out_free  = !r_o_valid || o_result.ready;
    assign e_commit  = r_e_valid && out_free;
    assign in_ready  = !r_clr_busy && (!r_e_valid || e_commit);
    assign in_accept = i_instr.valid && in_ready;

    assign i_instr.ready      = in_ready;
    assign o_result.valid     = r_o_valid;
    assign o_result.next_pc   = r_o_next_pc;
    assign o_result.out_valid = r_o_out_valid;
    assign o_result.out_byte  = r_o_out_byte;
    assign o_result.status    = r_o_status;

    // Execute: decode the held instruction against the cell just read.
    always_comb begin
        e_exec      = r_pc < r_len;
        e_cell      = r_e_fwd ? r_e_fwd_data : r_mem_q;
        n_pc        = t_pc'(r_pc + 1'b1);
        n_ptr       = r_ptr;
        e_wr_en     = 1'b0;
        e_wr_data   = e_cell;
        e_out_valid = 1'b0;
        e_out_byte  = '0;
        e_status    = ST_EXECUTED;
        if (!e_exec) begin
            n_pc     = r_pc;
            e_status = ST_FINISHED;
        end else begin
            unique case (r_e_mode)
                OP_ADD: begin
                    e_wr_en   = 1'b1;
                    e_wr_data = t_byte'(e_cell + r_e_add);
                end
                OP_JFWD: begin
                    n_ptr = r_e_addr;
                    if (e_cell == '0) begin
                        n_pc = r_e_target;
                    end
                end
                OP_JBWD: begin
                    n_ptr = r_e_addr;
                    if (e_cell != '0) begin
                        n_pc = r_e_target;
                    end
                end
                OP_ZERO: begin
                    e_wr_en   = 1'b1;
                    e_wr_data = '0;
                end
                OP_PUT: begin
                    e_out_valid = 1'b1;
                    e_out_byte  = e_cell;
                end
                OP_GET: begin
                    e_wr_en   = 1'b1;
                    e_wr_data = r_e_in;
                end
                OP_INVALID: begin
                    n_pc     = r_pc;
                    e_status = ST_HALTED;
                end
                default: begin
                    n_pc     = r_pc;
                    e_status = ST_HALTED;
                end
            endcase
        end
    end

    // Address of the incoming instruction uses the pointer as left by the one ahead.
    always_comb begin
        ptr_eff = e_commit ? n_ptr : r_ptr;
        in_addr = wrap_addr(ptr_eff, i_instr.ptr_offset);
        fwd_hit = e_commit && e_wr_en && (r_e_addr == in_addr);
    end

    // Memory write port: the clearing pass, else the execute write-back.
    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = e_commit && e_wr_en;
            mem_waddr = r_e_addr;
            mem_wdata = e_wr_data;
        end
    end

    // Tape memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tape[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mem_q <= r_tape[in_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_len      <= '0;
            r_pc       <= '0;
            r_ptr      <= '0;
            r_e_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= t_addr'(r_clr_addr + 1'b1);
                if (&r_clr_addr) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            if (e_commit) begin
                r_pc  <= n_pc;
                r_ptr <= n_ptr;
            end
            r_e_valid <= in_accept || (r_e_valid && !e_commit);
            if (e_commit) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Execute stage payload, loaded on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_e_mode     <= i_instr.mode;
            r_e_addr     <= in_addr;
            r_e_add      <= i_instr.add_value;
            r_e_target   <= i_instr.jump_target;
            r_e_in       <= i_instr.in_byte;
            r_e_fwd      <= fwd_hit;
            r_e_fwd_data <= e_wr_data;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (e_commit) begin
            r_o_next_pc   <= n_pc;
            r_o_out_valid <= e_out_valid;
            r_o_out_byte  <= e_out_byte;
            r_o_status    <= e_status;
        end
    end

    // Checks.
    assign e_straight = e_exec && (r_e_mode == OP_ADD || r_e_mode == OP_ZERO ||
                                   r_e_mode == OP_PUT || r_e_mode == OP_GET);

    `TMEC_ASSERT_NOW(a_no_accept_clearing, i_clk, i_rst_n, r_clr_busy, !in_accept, "instruction accepted during tape clear")
    `TMEC_ASSERT_NEXT(a_pc_hold_not_exec, i_clk, i_rst_n, e_commit && e_status != ST_EXECUTED, r_pc == $past(r_pc), "counter moved on a finished or halted item")
    `TMEC_ASSERT_NEXT(a_pc_step_straight, i_clk, i_rst_n, e_commit && e_straight, r_pc == t_pc'($past(r_pc) + 1'b1), "counter did not advance by one")
    `TMEC_ASSERT_NEXT(a_ptr_hold_idle, i_clk, i_rst_n, !e_commit, $stable(r_ptr), "pointer moved without a commit")

endmodule

`default_nettype wire

// ===== bench/tb_tape_machine_execute_core_top.sv =====
// Testbench of the tape machine execute core: directed and random instruction streams,
// checked result by result against a predictor kept inside the bench.
// Depends on tmec_pkg, the channel interfaces and the top level of the core.
`default_nettype none

module tb_tape_machine_execute_core_top;
    import tmec_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int TIMEOUT_CYCLES   = 400000;
    localparam int TAIL_CYCLES      = 6;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int STALL_CYCLES     = 300;
    // Opcode seven is unused by the core and must halt like the invalid opcode.
    localparam logic [MODE_W-1:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [MODE_W-1:0] mode;
        t_offset           ptr_offset;
        t_byte             add_value;
        t_pc               jump_target;
        t_byte             in_byte;
    } t_instr;

    typedef struct {
        t_pc     next_pc;
        logic    out_valid;
        t_byte   out_byte;
        t_status status;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    t_pc  i_cfg_data;

    tmec_instr_if  instr_ch ();
    tmec_result_if result_ch ();

    tape_machine_execute_core_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_instr    (instr_ch),
        .o_result   (result_ch)
    );

    // Own copy of the machine state and of the program length.
    t_byte tape_img [TAPE_CELLS];
    t_addr ptr_img;
    t_pc   pc_img;
    t_pc   len_img;

    t_outcome pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int mismatches    = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Tape cell at the pointer moved by a signed offset, wrapping around the tape.
    function automatic t_addr cell_addr(input t_offset off);
        int sum;
        sum = int'(ptr_img) + int'(off);
        return t_addr'(sum);
    endfunction

    // Executes one instruction on the state copy and gives the result it must produce.
    task automatic predict_execution(input t_instr ins, output t_outcome res);
        t_addr addr;
        t_pc   nxt;
        addr          = cell_addr(ins.ptr_offset);
        nxt           = pc_img + 1'b1;
        res.out_valid = 1'b0;
        res.out_byte  = '0;
        res.status    = ST_EXECUTED;
        if (pc_img >= len_img) begin
            res.status = ST_FINISHED;
            nxt        = pc_img;
        end else begin
            case (ins.mode)
                OP_ADD: begin
                    tape_img[addr] = tape_img[addr] + ins.add_value;
                end
                OP_JFWD: begin
                    ptr_img = addr;
                    if (tape_img[addr] == '0) nxt = ins.jump_target;
                end
                OP_JBWD: begin
                    ptr_img = addr;
                    if (tape_img[addr] != '0) nxt = ins.jump_target;
                end
                OP_ZERO: begin
                    tape_img[addr] = '0;
                end
                OP_PUT: begin
                    res.out_valid = 1'b1;
                    res.out_byte  = tape_img[addr];
                end
                OP_GET: begin
                    tape_img[addr] = ins.in_byte;
                end
                default: begin
                    res.status = ST_HALTED;
                    nxt        = pc_img;
                end
            endcase
            pc_img = nxt;
        end
        res.next_pc = nxt;
    endtask

    function automatic t_instr make_instr(input logic [MODE_W-1:0] m, input int off,
                                          input int addv, input int tgt, input int inb);
        t_instr ins;
        ins.mode        = m;
        ins.ptr_offset  = t_offset'(off);
        ins.add_value   = t_byte'(addv);
        ins.jump_target = t_pc'(tgt);
        ins.in_byte     = t_byte'(inb);
        return ins;
    endfunction

    // Mostly small moves so that the pointer stays among cells already written.
    function automatic t_offset random_offset();
        int pick;
        int near;
        pick = $urandom_range(99);
        near = $urandom_range(16);
        if (pick < 70) return t_offset'(near - 8);
        if (pick < 85) return t_offset'($urandom);
        if (pick < 93) return t_offset'(32767 - int'($urandom_range(3)));
        return t_offset'(-32768 + int'($urandom_range(3)));
    endfunction

    // A jump that is certain to be taken, given the cell it will land on.
    function automatic t_instr taken_jump(input t_offset off, input t_pc target);
        t_instr ins;
        t_addr  a;
        a               = cell_addr(off);
        ins.mode        = (tape_img[a] == '0) ? OP_JFWD : OP_JBWD;
        ins.ptr_offset  = off;
        ins.add_value   = t_byte'($urandom);
        ins.jump_target = target;
        ins.in_byte     = t_byte'($urandom);
        return ins;
    endfunction

    // Random instruction at the current counter; the last one loops back into the program.
    function automatic t_instr random_instr();
        t_instr ins;
        int     pick;
        pick            = $urandom_range(99);
        ins.ptr_offset  = random_offset();
        ins.add_value   = t_byte'($urandom);
        ins.jump_target = t_pc'($urandom_range(int'(len_img) - 1, 0));
        ins.in_byte     = ($urandom_range(7) == 0) ? t_byte'(0) : t_byte'($urandom);
        if (pick < 3)       ins.mode = $urandom_range(1) ? OP_UNUSED : OP_INVALID;
        else if (pick < 23) ins.mode = OP_ADD;
        else if (pick < 37) ins.mode = OP_JFWD;
        else if (pick < 51) ins.mode = OP_JBWD;
        else if (pick < 59) ins.mode = OP_ZERO;
        else if (pick < 79) ins.mode = OP_PUT;
        else                ins.mode = OP_GET;
        if (int'(pc_img) + 1 >= int'(len_img) && ins.mode != OP_INVALID &&
            ins.mode != OP_UNUSED) begin
            ins = taken_jump(ins.ptr_offset, ins.jump_target);
        end
        return ins;
    endfunction

    // Offers one instruction, with random idle cycles first, and records its result.
    task automatic send_item(input t_instr ins);
        t_outcome res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            instr_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        instr_ch.valid       <= 1'b1;
        instr_ch.mode        <= ins.mode;
        instr_ch.ptr_offset  <= ins.ptr_offset;
        instr_ch.add_value   <= ins.add_value;
        instr_ch.jump_target <= ins.jump_target;
        instr_ch.in_byte     <= ins.in_byte;
        do @(posedge i_clk); while (!instr_ch.ready);
        predict_execution(ins, res);
        pending_results.insert(pending_results.size(), res);
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic wait_idle();
        @(negedge i_clk);
        instr_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input t_pc len);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        len_img     = len;
    endtask

    // Moves the counter below a limit with a taken jump, while the program still runs.
    task automatic steer_pc(input int limit);
        int bound;
        if (pc_img < len_img) begin
            bound = (limit < int'(len_img)) ? limit : int'(len_img);
            send_item(taken_jump(random_offset(), t_pc'($urandom_range(bound - 1, 0))));
            wait_idle();
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) $display("mismatch: %s", what);
    endtask

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each result transaction is compared with the oldest expected result.
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result with none expected: pc %0d status %0d",
                                        result_ch.next_pc, result_ch.status));
            end else begin
                want = pending_results.pop_front();
                if (result_ch.next_pc !== want.next_pc || result_ch.out_valid !== want.out_valid ||
                    result_ch.out_byte !== want.out_byte || result_ch.status !== want.status) begin
                    note_mismatch($sformatf(
                        "expected pc %0d ov %0d byte %0d st %0d, got pc %0d ov %0d byte %0d st %0d",
                        want.next_pc, want.out_valid, want.out_byte, want.status,
                        result_ch.next_pc, result_ch.out_valid, result_ch.out_byte,
                        result_ch.status));
                end
            end
        end
    end

    // With a zero length every instruction reports finished and changes nothing.
    task automatic test_finished_after_reset();
        write_length(t_pc'(0));
        send_item(make_instr(OP_ADD, 0, 255, 0, 0));
        send_item(make_instr(OP_GET, 1, 0, 0, 255));
        send_item(make_instr(OP_JFWD, 3, 0, 5, 0));
        wait_idle();
    endtask

    // Every opcode, field extremes, byte wrap, tape wrap both ways, both jump outcomes.
    task automatic test_directed_ops();
        write_length(t_pc'(CODE_DEPTH));
        send_item(make_instr(OP_PUT, 0, 0, 0, 0));
        send_item(make_instr(OP_ADD, 0, 255, 0, 0));
        send_item(make_instr(OP_ADD, 0, 1, 0, 0));
        send_item(make_instr(OP_PUT, 0, 0, 0, 0));
        send_item(make_instr(OP_GET, -1, 0, 0, 255));
        send_item(make_instr(OP_PUT, 32767, 0, 0, 0));
        send_item(make_instr(OP_ADD, -32768, 7, 0, 0));
        send_item(make_instr(OP_PUT, 0, 0, 0, 0));
        send_item(make_instr(OP_ZERO, 0, 0, 0, 0));
        send_item(make_instr(OP_PUT, 0, 0, 0, 0));
        send_item(make_instr(OP_GET, 5, 0, 0, 0));
        send_item(make_instr(OP_GET, 3, 0, 0, 165));
        send_item(make_instr(OP_JFWD, 3, 0, 4095, 0));
        send_item(make_instr(OP_JBWD, 0, 0, 10, 0));
        send_item(make_instr(OP_JFWD, 2, 0, 0, 0));
        send_item(make_instr(OP_JBWD, 0, 0, 4095, 0));
        send_item(make_instr(OP_INVALID, 32767, 255, 4095, 255));
        send_item(make_instr(OP_UNUSED, -32768, 255, 4095, 255));
        send_item(make_instr(OP_JFWD, -32768, 0, 0, 0));
        send_item(make_instr(OP_JBWD, 32767, 0, 7, 0));
        send_item(make_instr(OP_PUT, -32768, 0, 0, 0));
        send_item(make_instr(OP_GET, 0, 255, 0, 0));
        send_item(make_instr(OP_PUT, 0, 0, 0, 0));
        wait_idle();
    endtask

    // A taken jump at or beyond the length finishes the program; the instructions
    // that follow leave the counter, pointer and tape as they were.
    task automatic test_jump_beyond(input int len, input int target);
        steer_pc(len);
        write_length(t_pc'(len));
        send_item(taken_jump(random_offset(), t_pc'(target)));
        send_item(random_instr());
        send_item(random_instr());
        wait_idle();
    endtask

    // Random program run at a given length and idling profile, with occasional drains.
    task automatic test_random_program(input int len, input int s_pct, input int r_pct,
                                       input int count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        steer_pc(len);
        write_length(t_pc'(len));
        for (int n = 0; n < count; n++) begin
            send_item(random_instr());
            if ($urandom_range(149) == 0) wait_idle();
        end
        wait_idle();
    endtask

    // The receiver holds off while the sender keeps offering, so the core stalls its input.
    task automatic test_result_stall(input int count);
        send_idle_pct = 0;
        hold_request  = STALL_CYCLES;
        for (int n = 0; n < count; n++) send_item(random_instr());
        wait_idle();
    endtask

    initial begin
        instr_ch.valid       = 1'b0;
        instr_ch.mode        = OP_INVALID;
        instr_ch.ptr_offset  = '0;
        instr_ch.add_value   = '0;
        instr_ch.jump_target = '0;
        instr_ch.in_byte     = '0;
        result_ch.ready      = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_data           = '0;
        i_rst_n              = 1'b0;
        foreach (tape_img[i]) tape_img[i] = '0;
        ptr_img = '0;
        pc_img  = '0;
        len_img = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_finished_after_reset();
        test_directed_ops();
        test_jump_beyond(16, 20);
        test_random_program(2047, 12, 52, 650);
        test_random_program(int'($urandom_range(4095, 2048)), 52, 12, 650);
        test_random_program(2, 0, 0, 150);
        test_random_program(CODE_DEPTH, 0, 0, 400);
        test_result_stall(60);
        test_jump_beyond(CODE_DEPTH, CODE_DEPTH);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tmec_pkg.sv
hw/rtl/tmec_channels.sv
hw/rtl/tape_machine_execute_core_top.sv
bench/tb_tape_machine_execute_core_top.sv
